[rtl/ssc_pkg.sv]
// Shared types, constants and helper functions for the case-folding substring search.
// No dependencies; every other file of the block imports this package.
package ssc_pkg;

    localparam int unsigned CfgDataWidth = 64;
    localparam int unsigned CfgIndexWidth = 2;
    localparam int unsigned LenWidth = 5;

    // ASCII bounds of the lowercase letters and the distance to uppercase
    localparam logic [7:0] LowerA = 8'd97;
    localparam logic [7:0] LowerZ = 8'd122;
    localparam logic [7:0] CaseOffset = 8'd32;

    // Register indexes of the configuration port
    typedef enum logic [CfgIndexWidth-1:0] {
        t_cfg_pattern_lo  = 2'd0,
        t_cfg_pattern_hi  = 2'd1,
        t_cfg_pattern_len = 2'd2,
        t_cfg_fold_case   = 2'd3
    } t_cfg_reg;

    // Control handed to every cell in the row
    typedef struct packed {
        logic [7:0]          chr;   // folded text character
        logic                fold;  // case folding on
        logic [LenWidth-1:0] len;   // configured pattern length
        logic                upd;   // advance partial matches this cycle
        logic                clr;   // end of text: drop partial matches
    } t_cell_ctl;

    // Fold A-Z to a-z when folding is on; all other bytes pass unchanged
    function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic f);
        logic is_upper;
        is_upper = (b >= (LowerA - CaseOffset)) && (b <= (LowerZ - CaseOffset));
        return (f && is_upper) ? (b + CaseOffset) : b;
    endfunction

endpackage

[rtl/ssc_cell.sv]
// One cell of the shift-and row: holds one pattern byte position and its partial-match bit.
// Depends on ssc_pkg for the control struct and the case folding function.
module ssc_cell #(
    parameter int unsigned IDX = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ssc_pkg::t_cell_ctl i_ctl,
    input  logic [7:0]        i_pat_byte,
    input  logic              i_prev_bit,
    input  logic              i_prev_en,
    output logic              o_bit,
    output logic              o_next,
    output logic              o_en
);
    import ssc_pkg::*;

    localparam logic [LenWidth-1:0] Pos = LenWidth'(IDX);

    logic r_bit;
    logic n_bit;
    logic hit;

    // Enable runs down the row: position in use and no zero byte up to here
    assign o_en = i_prev_en && (i_ctl.len > Pos) && (i_pat_byte != 8'd0);

    // Compare the folded pattern byte with the folded text character
    assign hit = (fold_byte(i_pat_byte, i_ctl.fold) == i_ctl.chr);

    // Advance on a character, hold otherwise
    always_comb begin
        n_bit = r_bit;
        if (i_ctl.upd) begin
            n_bit = i_prev_bit && hit && o_en;
        end
    end

    // Drop the bit at the end of a text
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= 1'b0;
        end else if (i_ctl.clr) begin
            r_bit <= 1'b0;
        end else begin
            r_bit <= n_bit;
        end
    end

    assign o_bit  = r_bit;
    assign o_next = n_bit;

endmodule

[rtl/substring_search_casefold.sv]
// Top level of the streaming substring search with optional ASCII case folding.
// Depends on ssc_pkg and instantiates a row of ssc_cell, one per pattern position.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+----------------------------
//   in      | input     | i_in_valid / o_in_stall   | i_text_byte, i_last
//   out     | output    | o_out_valid / i_out_stall | o_found
//   cfg     | input     | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// One word is taken every cycle unless in stalls; all partial matches update at once.
// The output register holds the result in the cycle after the last word is taken.
// The input stalls only while a result waits in the output register and out is stalled.
// Synchronous active-low reset clears the match state, the output and all registers.
// No clearing pass is needed after reset.
module substring_search_casefold #(
    parameter int unsigned PATTERN_MAX = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [7:0]                           i_text_byte,
    input  logic                                 i_last,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_found,
    input  logic                                 i_cfg_we,
    input  logic [ssc_pkg::CfgIndexWidth-1:0]    i_cfg_index,
    input  logic [ssc_pkg::CfgDataWidth-1:0]     i_cfg_data
);
    import ssc_pkg::*;

    localparam logic [LenWidth:0] LenMax = (LenWidth + 1)'(PATTERN_MAX);

    // Configuration registers
    logic [CfgDataWidth-1:0] r_pattern_lo;
    logic [CfgDataWidth-1:0] r_pattern_hi;
    logic [LenWidth-1:0]     r_pattern_len;
    logic                    r_fold_case;

    // Match and output state
    logic r_seen;
    logic n_seen;
    logic r_out_valid;
    logic r_found;

    logic [2*CfgDataWidth-1:0] pattern;
    logic [PATTERN_MAX-1:0]    part_bit;
    logic [PATTERN_MAX-1:0]    part_next;
    logic [PATTERN_MAX-1:0]    en;
    logic [PATTERN_MAX-1:0]    en_after;
    logic [PATTERN_MAX-1:0]    prev_bit;
    logic [PATTERN_MAX-1:0]    prev_en;
    logic                      in_acc;
    logic                      hit_end;
    t_cell_ctl                 ctl;

    // Write configuration; refuse a pattern length above the cell count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_lo  <= '0;
            r_pattern_hi  <= '0;
            r_pattern_len <= '0;
            r_fold_case   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                t_cfg_pattern_lo: begin
                    r_pattern_lo <= i_cfg_data;
                end
                t_cfg_pattern_hi: begin
                    r_pattern_hi <= i_cfg_data;
                end
                t_cfg_pattern_len: begin
                    if ({1'b0, i_cfg_data[LenWidth-1:0]} <= LenMax) begin
                        r_pattern_len <= i_cfg_data[LenWidth-1:0];
                    end
                end
                t_cfg_fold_case: begin
                    r_fold_case <= i_cfg_data[0];
                end
                default: begin
                    r_fold_case <= r_fold_case;
                end
            endcase
        end
    end

    assign pattern = {r_pattern_hi, r_pattern_lo};

    // Accept a word unless a waiting result cannot leave
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;

    // Broadcast control to the row; advance only on a real character and a non-empty pattern
    always_comb begin
        ctl.chr  = fold_byte(i_text_byte, r_fold_case);
        ctl.fold = r_fold_case;
        ctl.len  = r_pattern_len;
        ctl.upd  = in_acc && (i_text_byte != 8'd0) && en[0];
        ctl.clr  = in_acc && i_last;
    end

    // Row of cells: each takes its neighbour's bit and enable
    genvar g;
    generate
        for (g = 0; g < PATTERN_MAX; g++) begin : g_cell
            if (g == 0) begin : g_head
                assign prev_bit[g] = 1'b1;
                assign prev_en[g]  = 1'b1;
            end else begin : g_link
                assign prev_bit[g] = part_bit[g-1];
                assign prev_en[g]  = en[g-1];
            end

            ssc_cell #(
                .IDX (g)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (ctl),
                .i_pat_byte (pattern[8*g +: 8]),
                .i_prev_bit (prev_bit[g]),
                .i_prev_en  (prev_en[g]),
                .o_bit      (part_bit[g]),
                .o_next     (part_next[g]),
                .o_en       (en[g])
            );
        end
    endgenerate

    // Whole pattern matched: new bit of the last enabled cell
    assign en_after = en >> 1;
    assign hit_end  = ctl.upd && (|(part_next & en & ~en_after));

    always_comb begin
        n_seen = r_seen || hit_end;
    end

    // Hold the sticky match flag; drop it at the end of a text
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (ctl.clr) begin
            r_seen <= 1'b0;
        end else begin
            r_seen <= n_seen;
        end
    end

    // Output register: load on the last word, free when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
        end else if (ctl.clr) begin
            r_out_valid <= 1'b1;
            r_found     <= n_seen || !en[0];
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;

`ifndef NO_ASSERTIONS
    a_clear_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_last |=> (part_bit == '0) && !r_seen)
        else $error("match state not cleared after end of text");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_last |=> o_out_valid)
        else $error("no result after end of text");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !i_last && !(o_out_valid && i_out_stall) |=> !o_out_valid)
        else $error("result without end of text");

    a_empty_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_last && !en[0] |=> o_found)
        else $error("empty pattern not reported found");
`endif

endmodule

[tb/sv/tb_substring_search_casefold.sv]
`timescale 1ns / 100ps
// Self-checking bench for substring_search_casefold: streams text words, predicts each found flag.
// Depends on ssc_pkg and the block's RTL; holds its own shift-and model of the search.
module tb_substring_search_casefold;
    import ssc_pkg::*;

    localparam int PatternMax = 16;
    localparam int HoldPhase = 4;
    localparam int PhaseCount = 12;
    localparam int PhaseWords = 150;
    localparam logic [7:0] UpperA = "A";
    localparam logic [7:0] UpperZ = "Z";
    localparam logic [7:0] LowerA = "a";
    localparam logic [7:0] LowerZ = "z";
    localparam logic [7:0] CaseBit = 8'h20;

    typedef struct packed {
        logic [7:0] chr;
        logic       fin;
    } t_text_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic [7:0] i_text_byte = 8'd0;
    logic i_last = 1'b0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic o_found;
    logic i_cfg_we = 1'b0;
    logic [CfgIndexWidth-1:0] i_cfg_index = '0;
    logic [CfgDataWidth-1:0] i_cfg_data = '0;

    // Search model: configuration copy and match state
    logic [127:0] cfg_pat = '0;
    logic [4:0] cfg_len = '0;
    logic cfg_fold = 1'b0;
    logic [15:0] prefix_hits = '0;
    logic hit_seen = 1'b0;

    t_text_word text_fifo[$];
    bit found_due[$];
    int words_pushed = 0;
    int mismatches = 0;
    int phase_no = 0;

    // Driver and receiver state
    bit word_taken = 1'b0;
    t_text_word next_word;
    int burst_left = 0;
    int gap_left = 0;
    int hold_left = 0;
    bit hold_used = 1'b0;
    int stall_span = 0;
    int stall_pct = 0;
    bit exp_found;

    substring_search_casefold #(
        .PATTERN_MAX(PatternMax)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_text_byte(i_text_byte),
        .i_last(i_last),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_found(o_found),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic [7:0] fold_char(logic [7:0] c);
        if (cfg_fold && c >= UpperA && c <= UpperZ) return c + CaseBit;
        return c;
    endfunction

    // Pattern ends at pattern_len or at its first zero byte, whichever comes first
    function automatic int live_len();
        int n;
        n = 0;
        while (n < cfg_len && n < PatternMax && cfg_pat[8*n +: 8] != 8'd0) n++;
        return n;
    endfunction

    // Advance the partial matches by one word; a closing word yields the found flag
    function automatic void search_step(logic [7:0] chr, logic fin);
        int n;
        logic [16:0] hits;
        logic [16:0] mask;
        logic [7:0] fc;
        n = live_len();
        mask = (17'd1 << n) - 17'd1;
        if (chr != 8'd0 && n != 0) begin
            fc = fold_char(chr);
            hits = '0;
            for (int i = 0; i < n; i++) begin
                if (fold_char(cfg_pat[8*i +: 8]) == fc) hits[i] = 1'b1;
            end
            prefix_hits = 16'({prefix_hits, 1'b1} & hits & mask);
            if (prefix_hits[n-1]) hit_seen = 1'b1;
        end
        if (fin) begin
            found_due.push_back(hit_seen || n == 0);
            prefix_hits = '0;
            hit_seen = 1'b0;
        end
    endfunction

    function automatic logic [7:0] rand_letter();
        string alpha;
        alpha = "aAbBzZ@[`{";
        return alpha[$urandom_range(0, alpha.len() - 1)];
    endfunction

    // Flip letter case now and then, more often when folding should hide it
    function automatic logic [7:0] mixed_case(logic [7:0] c);
        bit is_letter;
        is_letter = (c >= UpperA && c <= UpperZ) || (c >= LowerA && c <= LowerZ);
        if (is_letter && $urandom_range(0, cfg_fold ? 1 : 7) == 0) return c ^ CaseBit;
        return c;
    endfunction

    task automatic push_word(logic [7:0] chr, logic fin);
        t_text_word w;
        w.chr = chr;
        w.fin = fin;
        text_fifo.push_back(w);
        words_pushed++;
    endtask

    // Write one register while the block is idle and mirror it in the model
    task automatic cfg_write(t_cfg_reg idx, logic [63:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        case (idx)
            t_cfg_pattern_lo: cfg_pat[63:0] = data;
            t_cfg_pattern_hi: cfg_pat[127:64] = data;
            t_cfg_pattern_len: begin
                if (data[4:0] <= PatternMax) cfg_len = data[4:0];
            end
            t_cfg_fold_case: cfg_fold = data[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Hold the sender until every queued word is taken and every result is in
    task automatic wait_idle();
        while (text_fifo.size() != 0 || i_in_valid || found_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // One phase: a fresh random setting, then texts that mostly carry the pattern
    task automatic random_phase(int n_words);
        int kind;
        int plen;
        int n;
        int tlen;
        int mode;
        int pos;
        int stop;
        logic [127:0] pat;
        logic [63:0] junk;
        logic [7:0] b;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 16; i++) pat[8*i +: 8] = rand_letter();
        junk = '0;
        case (kind)
            0: plen = 0;
            1: plen = 16;
            2: begin
                plen = $urandom_range(2, 16);
                pos = $urandom_range(0, plen - 1);
                pat[8*pos +: 8] = 8'd0;
            end
            3: begin
                pat = {$urandom, $urandom, $urandom, $urandom};
                plen = $urandom_range(0, 16);
                junk = {$urandom, $urandom} & ~64'h1F;
            end
            default: plen = $urandom_range(1, 5);
        endcase
        cfg_write(t_cfg_pattern_lo, pat[63:0]);
        cfg_write(t_cfg_pattern_hi, pat[127:64]);
        cfg_write(t_cfg_pattern_len, junk | 64'(plen));
        cfg_write(t_cfg_fold_case, (junk & ~64'h1) | 64'($urandom_range(0, 1)));
        // Too long a length must leave the old one in place
        if ($urandom_range(0, 3) == 0) cfg_write(t_cfg_pattern_len, 64'($urandom_range(17, 31)));
        n = live_len();
        stop = words_pushed + n_words;
        while (words_pushed < stop) begin
            tlen = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
            mode = $urandom_range(0, 9);
            pos = (tlen > 0) ? $urandom_range(0, tlen - 1) : 0;
            for (int k = 0; k < tlen; k++) begin
                if (mode < 6 && k == pos) begin
                    for (int j = 0; j < n; j++) push_word(mixed_case(cfg_pat[8*j +: 8]), 1'b0);
                end
                b = (mode == 9) ? 8'($urandom_range(0, 255)) : rand_letter();
                if ($urandom_range(0, 19) == 0) b = 8'd0;
                push_word(b, 1'b0);
            end
            b = ($urandom_range(0, 3) == 0) ? 8'd0 : rand_letter();
            if (mode == 9) b = 8'($urandom_range(0, 255));
            push_word(b, 1'b1);
        end
        // Leave a text open now and then so the next setting applies mid-text
        if ($urandom_range(0, 3) == 0) begin
            tlen = $urandom_range(1, 3);
            for (int k = 0; k < tlen; k++) push_word(rand_letter(), 1'b0);
        end
    endtask

    // Monitor: take input words into the model, check results against the oldest due flag
    always @(posedge i_clk) begin
        word_taken = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                word_taken = 1'b1;
                search_step(i_text_byte, i_last);
            end
            if (o_out_valid && !i_out_stall) begin
                if (found_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with nothing due, found=%0b", $realtime, o_found);
                end else begin
                    exp_found = found_due.pop_front();
                    if (o_found !== exp_found) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: found expected %0b, got %0b",
                                     $realtime, exp_found, o_found);
                    end
                end
            end
        end
    end

    // Driver: bursts of words with random gaps; hold the word while stalled
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || word_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (text_fifo.size() != 0) begin
                next_word = text_fifo.pop_front();
                i_text_byte <= next_word.chr;
                i_last <= next_word.fin;
                i_in_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall on a changing duty, with one long hold-off in a chosen phase
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (phase_no == HoldPhase && !hold_used) begin
            hold_used = 1'b1;
            hold_left = 400;
            i_out_stall <= 1'b1;
        end else begin
            if (stall_span == 0) begin
                stall_span = $urandom_range(16, 96);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 20;
                    2: stall_pct = 50;
                    default: stall_pct = 90;
                endcase
            end else begin
                stall_span--;
            end
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Stimulus and verdict
    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty pattern after reset: every text is found, the empty one too
        push_word(8'd0, 1'b1);
        push_word(8'hFF, 1'b1);
        wait_idle();

        // Pattern "Az" then 0xFF, folded
        cfg_write(t_cfg_pattern_lo, 64'h0000_0000_00FF_7A41);
        cfg_write(t_cfg_pattern_len, 64'd3);
        cfg_write(t_cfg_fold_case, 64'd1);
        push_word("a", 1'b0);
        push_word("Z", 1'b0);
        push_word(8'hFF, 1'b1);
        // A zero byte inside the text carries nothing and does not break the match
        push_word("a", 1'b0);
        push_word(8'd0, 1'b0);
        push_word("z", 1'b0);
        push_word(8'hFF, 1'b1);
        push_word(8'h01, 1'b0);
        push_word(8'h7F, 1'b0);
        push_word(8'h80, 1'b1);
        // Empty text against a non-empty pattern
        push_word(8'd0, 1'b1);
        wait_idle();

        // Exact compare
        cfg_write(t_cfg_fold_case, 64'd0);
        push_word("a", 1'b0);
        push_word("z", 1'b0);
        push_word(8'hFF, 1'b1);
        push_word("A", 1'b0);
        push_word("z", 1'b0);
        push_word(8'hFF, 1'b1);
        wait_idle();

        // Refused length, then a zero byte that cuts the pattern to "A"
        cfg_write(t_cfg_pattern_len, 64'd20);
        cfg_write(t_cfg_pattern_lo, 64'h0000_0000_005A_0041);
        push_word("@", 1'b0);
        push_word("[", 1'b1);
        push_word("A", 1'b0);
        wait_idle();

        // Full-length pattern set mid-text: the earlier hit still counts
        cfg_write(t_cfg_pattern_hi, 64'hFFFF_FFFF_FFFF_FFFF);
        cfg_write(t_cfg_pattern_lo, 64'h7F7F_7F7F_7F7F_7F7F);
        cfg_write(t_cfg_pattern_len, 64'd16);
        push_word("q", 1'b1);
        wait_idle();

        for (int p = 1; p <= PhaseCount; p++) begin
            phase_no = p;
            random_phase(PhaseWords);
            wait_idle();
        end

        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("substring_search_casefold regression: pass");
        end else begin
            $display("substring_search_casefold regression: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("substring_search_casefold regression: fail");
        $finish;
    end

endmodule
